// File: rtl/ngm_pkg.sv
// Package: shared types, preset codes, gradient constants and table builders.
`default_nettype none
package ngm_pkg;

   // Default table depths.
   localparam int DEF_SINE_TABLE_DEPTH  = 256;
   localparam int DEF_POWER_TABLE_DEPTH = 256;

   // Preset codes.
   localparam logic [1:0] PRESET_CLOUDS  = 2'd0;
   localparam logic [1:0] PRESET_MARBLE  = 2'd1;
   localparam logic [1:0] PRESET_FIRE    = 2'd2;
   localparam logic [1:0] PRESET_TERRAIN = 2'd3;

   // Level 1.0 in Q0.16 with the extra integer bit.
   localparam logic [16:0] T_ONE = 17'd65536;

   // Fixed-point constants of the marble phase and the sine builder.
   localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } colour_type;

   localparam colour_type SKY_C   = '{r: 8'd74,  g: 8'd144, b: 8'd217};
   localparam colour_type WHITE_C = '{r: 8'd255, g: 8'd255, b: 8'd255};
   localparam colour_type VEIN_C  = '{r: 8'd40,  g: 8'd40,  b: 8'd46};
   localparam colour_type BASE_C  = '{r: 8'd232, g: 8'd226, b: 8'd216};

   // Fire gradient.
   localparam int FIRE_STOPS = 5;
   localparam logic [16:0] FIRE_POS [FIRE_STOPS] =
      '{17'd0, 17'd22938, 17'd39322, 17'd53740, 17'd65536};
   localparam colour_type FIRE_COL [FIRE_STOPS] = '{
      '{r: 8'd10,  g: 8'd0,   b: 8'd0},
      '{r: 8'd120, g: 8'd10,  b: 8'd0},
      '{r: 8'd220, g: 8'd90,  b: 8'd0},
      '{r: 8'd255, g: 8'd190, b: 8'd40},
      '{r: 8'd255, g: 8'd250, b: 8'd210}};
   // Reciprocal of each segment's span, floor(2^32 / span); entry zero is unused.
   localparam logic [31:0] FIRE_RECIP [FIRE_STOPS] = '{
      32'd0,
      32'(64'd4294967296 / 64'd22938),
      32'(64'd4294967296 / 64'd16384),
      32'(64'd4294967296 / 64'd14418),
      32'(64'd4294967296 / 64'd11796)};

   // Terrain gradient.
   localparam int TERRAIN_STOPS = 7;
   localparam logic [16:0] TERRAIN_POS [TERRAIN_STOPS] =
      '{17'd0, 17'd24904, 17'd28836, 17'd32768, 17'd47186, 17'd57672, 17'd65536};
   localparam colour_type TERRAIN_COL [TERRAIN_STOPS] = '{
      '{r: 8'd15,  g: 8'd40,  b: 8'd90},
      '{r: 8'd40,  g: 8'd95,  b: 8'd175},
      '{r: 8'd215, g: 8'd200, b: 8'd140},
      '{r: 8'd70,  g: 8'd140, b: 8'd60},
      '{r: 8'd110, g: 8'd100, b: 8'd95},
      '{r: 8'd250, g: 8'd250, b: 8'd250},
      '{r: 8'd255, g: 8'd255, b: 8'd255}};
   localparam logic [31:0] TERRAIN_RECIP [TERRAIN_STOPS] = '{
      32'd0,
      32'(64'd4294967296 / 64'd24904),
      32'(64'd4294967296 / 64'd3932),
      32'(64'd4294967296 / 64'd3932),
      32'(64'd4294967296 / 64'd14418),
      32'(64'd4294967296 / 64'd10486),
      32'(64'd4294967296 / 64'd7864)};

   // Beat leaving the front stages: preset and the level that picks the colour.
   typedef struct packed {
      logic        valid;
      logic [1:0]  preset;
      logic [16:0] level;
   } front_type;

   // Beat entering the blend stage.
   typedef struct packed {
      logic        valid;
      colour_type  ca;
      colour_type  cb;
      logic [16:0] weight;
   } blend_type;

   // Map a signed Q1.15 value to a Q0.16 level, clamped to [0, 1.0].
   function automatic logic [16:0] normalize(input logic signed [15:0] s);
      logic signed [17:0] v;
      v = (18'(s) <<< 1) + 18'sd32768;
      if (v < 18'sd0) begin
         return 17'd0;
      end else if (v > 18'sd65536) begin
         return T_ONE;
      end
      return v[16:0];
   endfunction

   // Sine of a phase given as a 32-bit turn fraction, Q1.15, by quarter-wave
   // symmetry and a truncating Taylor series in Q30.
   function automatic logic signed [15:0] sine_entry(input logic [63:0] p);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [15:0] mag;
      quad = p[31:30];
      r = {34'd0, p[29:0]};
      if (quad[0]) begin
         r = 64'h4000_0000 - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      sum  = sum >> 15;
      if (sum > 64'd32767) begin
         sum = 64'd32767;
      end
      mag = sum[15:0];
      return quad[1] ? -$signed(mag) : $signed(mag);
   endfunction

   // q^1.4 for a Q0.16 level q: q times the largest Q0.12 root of q^2.
   function automatic logic [16:0] power_entry(input logic [63:0] q);
      logic [63:0] lim;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lim = (q * q) << 28;
      lo  = 64'd0;
      hi  = 64'd4096;
      for (int i = 0; i < 16; i++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (mid * mid * mid * mid * mid <= lim) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return 17'((q * lo) >> 12);
   endfunction

endpackage
`default_nettype wire

// File: rtl/ngm_if.sv
// Interfaces: request and response channels with valid/ready handshakes.
`default_nettype none
interface ngm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] noise_value;
   logic        [15:0] coord_x;
   logic        [15:0] coord_y;
   modport source (output valid, noise_value, coord_x, coord_y, input ready);
   modport sink   (input valid, noise_value, coord_x, coord_y, output ready);
endinterface

interface ngm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;
   modport source (output valid, pixel_argb, input ready);
   modport sink   (input valid, pixel_argb, output ready);
endinterface
`default_nettype wire

// File: rtl/ngm_front.sv
// Front stages: level, marble phase, shading curves and table lookups.
`default_nettype none
module ngm_front
   import ngm_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH  = DEF_SINE_TABLE_DEPTH,
   parameter int POWER_TABLE_DEPTH = DEF_POWER_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               stage_enable,
   input  wire logic               in_valid,
   input  wire logic [1:0]         in_preset,
   input  wire logic signed [15:0] in_noise,
   input  wire logic [15:0]        in_x,
   input  wire logic [15:0]        in_y,
   output front_type               front_out
);

   localparam int SW  = $clog2(SINE_TABLE_DEPTH);
   localparam int PW  = $clog2(POWER_TABLE_DEPTH + 1);
   localparam int SPW = 47 + SW + 1;
   localparam int PPW = 17 + PW + 1;

   // Constant tables, built at elaboration.
   logic signed [15:0] sine_tab  [SINE_TABLE_DEPTH];
   logic        [16:0] power_tab [POWER_TABLE_DEPTH + 1];

   for (genvar j = 0; j < SINE_TABLE_DEPTH; j++) begin : g_sine
      localparam logic [63:0] P = (64'(j) << 32) / SINE_TABLE_DEPTH;
      assign sine_tab[j] = sine_entry(P);
   end
   for (genvar k = 0; k <= POWER_TABLE_DEPTH; k++) begin : g_power
      localparam logic [63:0] Q = (64'(k) * 64'd65536) / POWER_TABLE_DEPTH;
      assign power_tab[k] = power_entry(Q);
   end

   // Stage A: level and marble phase in units of 2^-15 rad.
   logic               a_valid_ff, a_valid_in;
   logic [1:0]         a_preset_ff;
   logic [16:0]        a_t_ff, a_t_in;
   logic signed [24:0] a_theta_ff, a_theta_in;
   logic [16:0]        xy_sum;

   always_comb begin
      a_valid_in = in_valid;
      a_t_in     = normalize(in_noise);
      xy_sum     = 17'(in_x) + 17'(in_y);
      a_theta_in = $signed({8'd0, xy_sum}) * 25'sd48 + 25'(in_noise) * 25'sd12;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (stage_enable) begin
         a_valid_ff <= a_valid_in;
      end
      if (stage_enable) begin
         a_preset_ff <= in_preset;
         a_t_ff      <= a_t_in;
         a_theta_ff  <= a_theta_in;
      end
   end

   // Stage B: t squared, phase in turns, power table index.
   logic          b_valid_ff;
   logic [1:0]    b_preset_ff;
   logic [16:0]   b_t_ff;
   logic [16:0]   b_u_ff, b_u_in;
   logic [46:0]   b_frac_ff, b_frac_in;
   logic [PW-1:0] b_pidx_ff, b_pidx_in;
   logic [33:0]   sq;
   logic [63:0]   turns;
   logic [PPW-1:0] pprod;

   always_comb begin
      sq        = 34'(a_t_ff) * 34'(a_t_ff);
      b_u_in    = sq[32:16];
      turns     = 64'(a_theta_ff) * 64'(INV_TWO_PI_Q32);
      b_frac_in = turns[46:0];
      pprod     = PPW'(a_t_ff) * PPW'(POWER_TABLE_DEPTH);
      b_pidx_in = pprod[16 +: PW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (stage_enable) begin
         b_valid_ff <= a_valid_ff;
      end
      if (stage_enable) begin
         b_preset_ff <= a_preset_ff;
         b_t_ff      <= a_t_ff;
         b_u_ff      <= b_u_in;
         b_frac_ff   <= b_frac_in;
         b_pidx_ff   <= b_pidx_in;
      end
   end

   // Stage C: smoothstep, sine index, power table read.
   logic          c_valid_ff;
   logic [1:0]    c_preset_ff;
   logic [16:0]   c_t_ff;
   logic [16:0]   c_s_ff, c_s_in;
   logic [SW-1:0] c_sidx_ff, c_sidx_in;
   logic [16:0]   c_pval_ff;
   logic [17:0]   smooth_fac;
   logic [35:0]   smooth_prod;
   logic [SPW-1:0] sprod;

   always_comb begin
      smooth_fac  = 18'd196608 - (18'(b_t_ff) << 1);
      smooth_prod = 36'(b_u_ff) * 36'(smooth_fac);
      c_s_in      = smooth_prod[32:16];
      sprod       = SPW'(b_frac_ff) * SPW'(SINE_TABLE_DEPTH);
      c_sidx_in   = sprod[47 +: SW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (stage_enable) begin
         c_valid_ff <= b_valid_ff;
      end
      if (stage_enable) begin
         c_preset_ff <= b_preset_ff;
         c_t_ff      <= b_t_ff;
         c_s_ff      <= c_s_in;
         c_sidx_ff   <= c_sidx_in;
         c_pval_ff   <= power_tab[b_pidx_ff];
      end
   end

   // Stage D: sine table read and choice of the level per preset.
   front_type d_ff, d_in;

   always_comb begin
      d_in.valid  = c_valid_ff;
      d_in.preset = c_preset_ff;
      unique case (c_preset_ff)
         PRESET_CLOUDS: d_in.level = c_s_ff;
         PRESET_MARBLE: d_in.level = normalize(sine_tab[c_sidx_ff]);
         PRESET_FIRE:   d_in.level = c_pval_ff;
         default:       d_in.level = c_t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (stage_enable) begin
         d_ff.valid <= d_in.valid;
      end
      if (stage_enable) begin
         d_ff.preset <= d_in.preset;
         d_ff.level  <= d_in.level;
      end
   end

   assign front_out = d_ff;

endmodule
`default_nettype wire

// File: rtl/ngm_gradient.sv
// Gradient stages: segment select and the local weight by reciprocal multiply.
`default_nettype none
module ngm_gradient
   import ngm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      stage_enable,
   input  wire front_type front_in,
   output blend_type      blend_out
);

   // Stage E: find the segment, or pass the level straight through.
   logic        e_valid_ff;
   logic        e_direct_ff, e_direct_in;
   logic [16:0] e_level_ff;
   logic [15:0] e_diff_ff, e_diff_in;
   logic [15:0] e_span_ff, e_span_in;
   logic [31:0] e_recip_ff, e_recip_in;
   colour_type  e_ca_ff, e_ca_in;
   colour_type  e_cb_ff, e_cb_in;
   logic [2:0]  seg;
   logic [2:0]  seg_lo;

   always_comb begin
      seg         = 3'd1;
      seg_lo      = 3'd0;
      e_direct_in = 1'b0;
      e_diff_in   = 16'd0;
      e_span_in   = 16'd0;
      e_recip_in  = 32'd0;
      e_ca_in     = SKY_C;
      e_cb_in     = WHITE_C;
      unique case (front_in.preset)
         PRESET_CLOUDS: begin
            e_direct_in = 1'b1;
         end
         PRESET_MARBLE: begin
            e_direct_in = 1'b1;
            e_ca_in     = VEIN_C;
            e_cb_in     = BASE_C;
         end
         PRESET_FIRE: begin
            for (int i = FIRE_STOPS - 1; i >= 1; i--) begin
               if (front_in.level <= FIRE_POS[i]) begin
                  seg = 3'(i);
               end
            end
            seg_lo     = 3'(seg - 3'd1);
            e_diff_in  = 16'(front_in.level - FIRE_POS[seg_lo]);
            e_span_in  = 16'(FIRE_POS[seg] - FIRE_POS[seg_lo]);
            e_recip_in = FIRE_RECIP[seg];
            e_ca_in    = FIRE_COL[seg_lo];
            e_cb_in    = FIRE_COL[seg];
         end
         default: begin
            for (int i = TERRAIN_STOPS - 1; i >= 1; i--) begin
               if (front_in.level <= TERRAIN_POS[i]) begin
                  seg = 3'(i);
               end
            end
            seg_lo     = 3'(seg - 3'd1);
            e_diff_in  = 16'(front_in.level - TERRAIN_POS[seg_lo]);
            e_span_in  = 16'(TERRAIN_POS[seg] - TERRAIN_POS[seg_lo]);
            e_recip_in = TERRAIN_RECIP[seg];
            e_ca_in    = TERRAIN_COL[seg_lo];
            e_cb_in    = TERRAIN_COL[seg];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (stage_enable) begin
         e_valid_ff <= front_in.valid;
      end
      if (stage_enable) begin
         e_direct_ff <= e_direct_in;
         e_level_ff  <= front_in.level;
         e_diff_ff   <= e_diff_in;
         e_span_ff   <= e_span_in;
         e_recip_ff  <= e_recip_in;
         e_ca_ff     <= e_ca_in;
         e_cb_ff     <= e_cb_in;
      end
   end

   // Stage F: quotient estimate, at most one below the true value.
   logic        f_valid_ff;
   logic        f_direct_ff;
   logic [16:0] f_est_ff, f_est_in;
   logic [15:0] f_diff_ff;
   logic [15:0] f_span_ff;
   colour_type  f_ca_ff;
   colour_type  f_cb_ff;
   logic [47:0] est_prod;

   always_comb begin
      est_prod = 48'(e_diff_ff) * 48'(e_recip_ff);
      f_est_in = e_direct_ff ? e_level_ff : est_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (stage_enable) begin
         f_valid_ff <= e_valid_ff;
      end
      if (stage_enable) begin
         f_direct_ff <= e_direct_ff;
         f_est_ff    <= f_est_in;
         f_diff_ff   <= e_diff_ff;
         f_span_ff   <= e_span_ff;
         f_ca_ff     <= e_ca_ff;
         f_cb_ff     <= e_cb_ff;
      end
   end

   // Stage G: bump the estimate when the remainder still holds a full span.
   blend_type   g_ff, g_in;
   logic [33:0] rem;
   logic        bump;

   always_comb begin
      rem         = 34'({f_diff_ff, 16'd0}) - 34'(f_est_ff) * 34'(f_span_ff);
      bump        = !f_direct_ff && (rem >= 34'(f_span_ff));
      g_in.valid  = f_valid_ff;
      g_in.ca     = f_ca_ff;
      g_in.cb     = f_cb_ff;
      g_in.weight = f_est_ff + 17'(bump);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff.valid <= 1'b0;
      end else if (stage_enable) begin
         g_ff.valid <= g_in.valid;
      end
      if (stage_enable) begin
         g_ff.ca     <= g_in.ca;
         g_ff.cb     <= g_in.cb;
         g_ff.weight <= g_in.weight;
      end
   end

   assign blend_out = g_ff;

endmodule
`default_nettype wire

// File: rtl/ngm_blend.sv
// Blend stage: per-channel linear interpolation into the output pixel register.
`default_nettype none
module ngm_blend
   import ngm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      stage_enable,
   input  wire blend_type blend_in,
   output logic           out_valid,
   output logic [31:0]    out_pixel
);

   // Floor of a + (b - a) * w for one 8-bit channel.
   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [16:0] w);
      logic [24:0] acc;
      acc = 25'(a) * 25'(T_ONE - w) + 25'(b) * 25'(w);
      return acc[23:16];
   endfunction

   logic        valid_ff;
   logic [31:0] pixel_ff, pixel_in;

   always_comb begin
      pixel_in = {8'hFF,
                  mix(blend_in.ca.r, blend_in.cb.r, blend_in.weight),
                  mix(blend_in.ca.g, blend_in.cb.g, blend_in.weight),
                  mix(blend_in.ca.b, blend_in.cb.b, blend_in.weight)};
   end

   // Output register holds the beat until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_enable) begin
         valid_ff <= blend_in.valid;
      end
      if (stage_enable) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule
`default_nettype wire

// File: rtl/noise_to_color_gradient_map.sv
// An accepted request beat passes stages A to G and the blend register before its response beat.
// Throughput: one pixel per cycle; the eight-stage pipeline holds as a whole
// while the response beat waits, so ready drops only when the output is full.
// Reset clears every stage's valid bit and sets the preset to clouds; the
// sine and power tables are constants and need no fill after reset.
`default_nettype none
module noise_to_color_gradient_map
   import ngm_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH  = DEF_SINE_TABLE_DEPTH,
   parameter int POWER_TABLE_DEPTH = DEF_POWER_TABLE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ngm_req_if.sink         req_chan,
   ngm_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data
);

   logic [1:0]  preset_ff;
   logic        stage_enable;
   logic        out_valid;
   logic [31:0] out_pixel;
   front_type   front_beat;
   blend_type   blend_beat;

   // Preset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff <= PRESET_CLOUDS;
      end else if (csr_write_enable) begin
         preset_ff <= csr_write_data;
      end
   end

   // The whole pipeline moves unless a finished beat is still waiting.
   assign stage_enable   = !out_valid || rsp_chan.ready;
   assign req_chan.ready = stage_enable;

   ngm_front #(
      .SINE_TABLE_DEPTH  (SINE_TABLE_DEPTH),
      .POWER_TABLE_DEPTH (POWER_TABLE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .stage_enable (stage_enable),
      .in_valid     (req_chan.valid),
      .in_preset    (preset_ff),
      .in_noise     (req_chan.noise_value),
      .in_x         (req_chan.coord_x),
      .in_y         (req_chan.coord_y),
      .front_out    (front_beat)
   );

   ngm_gradient u_gradient (
      .clock        (clock),
      .reset        (reset),
      .stage_enable (stage_enable),
      .front_in     (front_beat),
      .blend_out    (blend_beat)
   );

   ngm_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .stage_enable (stage_enable),
      .blend_in     (blend_beat),
      .out_valid    (out_valid),
      .out_pixel    (out_pixel)
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.pixel_argb = out_pixel;

endmodule
`default_nettype wire
